FILE: rtl/core/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 counter mode package
// Shared types, tables and byte functions for the counter-mode cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

   localparam int ACC_ROUNDS = 10;
   localparam int ACC_BLOCK_W = 128;
   localparam int ACC_HALF_W = 64;
   localparam int ACC_INDEX_W = 8;

   typedef enum logic [ACC_INDEX_W-1:0] {
      REG_KEY_HIGH   = 8'd0,
      REG_KEY_LOW    = 8'd1,
      REG_NONCE_HIGH = 8'd2,
      REG_NONCE_LOW  = 8'd3
   } acc_reg_type;

   typedef struct packed {
      logic                   valid;
      logic [ACC_BLOCK_W-1:0] state;
      logic [ACC_BLOCK_W-1:0] rkey;
      logic [ACC_BLOCK_W-1:0] text;
   } acc_stage_type;

   localparam logic [7:0] ACC_RCON [ACC_ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] ACC_SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] acc_xtime(input logic [7:0] x);
      acc_xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte 0 of a block sits in the most significant bits.
   function automatic logic [7:0] acc_byte(input logic [ACC_BLOCK_W-1:0] b, input int i);
      acc_byte = b[ACC_BLOCK_W-1-8*i -: 8];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aes128_round_cell.sv
// ----------------------------------------------------------------------------
// AES-128 round cell
// One encryption round with its round key expanded from the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_round_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      enable,
   input  wire logic [7:0]                rcon,
   input  wire logic                      last_round,
   input  wire aes128_pkg::acc_stage_type stage_in,
   output      aes128_pkg::acc_stage_type stage_out
);
   import aes128_pkg::*;

   logic [7:0] sb [16];
   logic [7:0] mx [16];
   logic [7:0] kb [16];
   logic [7:0] nk [16];
   logic [7:0] tw [4];
   logic [7:0] all_x;
   logic [ACC_BLOCK_W-1:0] state_in;
   logic [ACC_BLOCK_W-1:0] rkey_in;
   logic valid_ff;
   logic [ACC_BLOCK_W-1:0] state_ff;
   logic [ACC_BLOCK_W-1:0] rkey_ff;
   logic [ACC_BLOCK_W-1:0] text_ff;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         kb[i] = acc_byte(stage_in.rkey, i);
      end
      tw[0] = ACC_SBOX[kb[13]] ^ rcon;
      tw[1] = ACC_SBOX[kb[14]];
      tw[2] = ACC_SBOX[kb[15]];
      tw[3] = ACC_SBOX[kb[12]];
      for (int j = 0; j < 4; j++) begin
         nk[j]      = kb[j] ^ tw[j];
         nk[4 + j]  = kb[4 + j] ^ kb[j] ^ tw[j];
         nk[8 + j]  = kb[8 + j] ^ kb[4 + j] ^ kb[j] ^ tw[j];
         nk[12 + j] = kb[12 + j] ^ kb[8 + j] ^ kb[4 + j] ^ kb[j] ^ tw[j];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sb[4*c + r] = ACC_SBOX[acc_byte(stage_in.state, 4*((c + r) % 4) + r)];
         end
      end
      all_x = 8'h00;
      for (int c = 0; c < 4; c++) begin
         all_x = sb[4*c] ^ sb[4*c + 1] ^ sb[4*c + 2] ^ sb[4*c + 3];
         for (int r = 0; r < 4; r++) begin
            mx[4*c + r] = sb[4*c + r] ^ all_x ^ acc_xtime(sb[4*c + r] ^ sb[4*c + ((r + 1) % 4)]);
         end
      end
      for (int i = 0; i < 16; i++) begin
         rkey_in[ACC_BLOCK_W-1-8*i -: 8]  = nk[i];
         state_in[ACC_BLOCK_W-1-8*i -: 8] = (last_round ? sb[i] : mx[i]) ^ nk[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
         rkey_ff  <= rkey_in;
         text_ff  <= stage_in.text;
      end
   end

   assign stage_out = '{valid: valid_ff, state: state_ff, rkey: rkey_ff, text: text_ff};

endmodule

`default_nettype wire

FILE: rtl/core/aes128_ctr_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 counter mode block cipher
// XORs each text block with the AES-128 encryption of nonce XOR counter.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake         | Payload
//  req     | in        | req_valid/stall   | block_high, block_low, first_block
//  rsp     | out       | rsp_valid/stall   | text_high, text_low
//  csr     | in        | csr_write_enable  | csr_index, csr_write_data
//
// One block is taken every cycle unless a held result stalls the row; an input
// stage that adds the initial round key feeds a row of ten round cells.
// The whole row advances together, so a held result stalls the row and the
// input, while a bubble at the output does not stall the row. Reset is
// synchronous and clears the stage valids, the counter and the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_ctr_block_cipher (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [aes128_pkg::ACC_HALF_W-1:0]   req_block_high,
   input  wire logic [aes128_pkg::ACC_HALF_W-1:0]   req_block_low,
   input  wire logic                                req_first_block,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [aes128_pkg::ACC_HALF_W-1:0]   rsp_text_high,
   output      logic [aes128_pkg::ACC_HALF_W-1:0]   rsp_text_low,
   input  wire logic                                csr_write_enable,
   input  wire logic [aes128_pkg::ACC_INDEX_W-1:0]  csr_index,
   input  wire logic [aes128_pkg::ACC_HALF_W-1:0]   csr_write_data
);
   import aes128_pkg::*;

   logic [ACC_BLOCK_W-1:0] key_ff;
   logic [ACC_BLOCK_W-1:0] nonce_ff;
   logic [ACC_BLOCK_W-1:0] counter_ff;
   logic [ACC_BLOCK_W-1:0] counter_used;
   logic [ACC_BLOCK_W-1:0] counter_in;
   logic                   enable;
   logic                   accept;
   acc_stage_type          stage_in;
   acc_stage_type          stage_ff;
   acc_stage_type          chain [ACC_ROUNDS+1];

   assign enable    = !(chain[ACC_ROUNDS].valid && rsp_stall);
   assign req_stall = !enable;
   assign accept    = req_valid && enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         nonce_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_KEY_HIGH:   key_ff[ACC_BLOCK_W-1:ACC_HALF_W]   <= csr_write_data;
            REG_KEY_LOW:    key_ff[ACC_HALF_W-1:0]             <= csr_write_data;
            REG_NONCE_HIGH: nonce_ff[ACC_BLOCK_W-1:ACC_HALF_W] <= csr_write_data;
            REG_NONCE_LOW:  nonce_ff[ACC_HALF_W-1:0]           <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign counter_used = req_first_block ? '0 : counter_ff;
   assign counter_in   = counter_used + ACC_BLOCK_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (accept) begin
         counter_ff <= counter_in;
      end
   end

   always_comb begin
      stage_in.valid = req_valid;
      stage_in.state = nonce_ff ^ counter_used ^ key_ff;
      stage_in.rkey  = key_ff;
      stage_in.text  = {req_block_high, req_block_low};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign chain[0] = stage_ff;

   for (genvar g = 0; g < ACC_ROUNDS; g++) begin : g_round
      aes128_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .rcon       (ACC_RCON[g]),
         .last_round (g == ACC_ROUNDS - 1),
         .stage_in   (chain[g]),
         .stage_out  (chain[g+1])
      );
   end

   assign rsp_valid     = chain[ACC_ROUNDS].valid;
   assign rsp_text_high = chain[ACC_ROUNDS].text[ACC_BLOCK_W-1:ACC_HALF_W]
                        ^ chain[ACC_ROUNDS].state[ACC_BLOCK_W-1:ACC_HALF_W];
   assign rsp_text_low  = chain[ACC_ROUNDS].text[ACC_HALF_W-1:0]
                        ^ chain[ACC_ROUNDS].state[ACC_HALF_W-1:0];

   a_stall_only_on_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_first_block_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_first_block) |=> (counter_ff == ACC_BLOCK_W'(1)))
      else $error("counter did not restart on a first block");

   a_counter_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!accept && !$past(reset)) |=> $stable(counter_ff))
      else $error("counter moved without a transaction");

endmodule

`default_nettype wire
